>>> design/sphere_capsule_contact_assert.svh
// Assertion macros shared by the sphere against capsule contact block.
`ifndef SPHERE_CAPSULE_CONTACT_ASSERT_SVH
`define SPHERE_CAPSULE_CONTACT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCC_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SCC_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scc: next-cycle check failed");

`endif

>>> design/scc_pkg.sv
// Types, constants and helper functions of the sphere against capsule contact block.
`default_nettype none

package scc_pkg;

  // Configuration register map, one 32-bit word per register.
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_CEN_X  = 3'd0;
  localparam logic [2:0] REG_CEN_Y  = 3'd1;
  localparam logic [2:0] REG_CEN_Z  = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  // Reset values of the capsule registers.
  localparam logic signed [15:0] AXIS_Z_RST = 16'sd16384;
  localparam logic [30:0]        RADIUS_RST = 31'd65536;
  localparam logic [30:0]        HEIGHT_RST = 31'd131072;

  // Pi in Q2.30.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Square root unit: 32 result bits, four per stage.
  localparam int SQRT_STAGES = 8;
  localparam int SQRT_STEPS  = 4;

  // Divider unit: 31-bit overlap quotient and 15-bit direction quotients.
  localparam int DIV_STAGES = 8;
  localparam int QDIV_STEPS = 4;
  localparam int DDIV_STEPS = 2;
  localparam int Q_BITS     = 31;
  localparam int D_BITS     = 15;

  // One input item.
  typedef struct packed {
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic [30:0]        sphere_radius;
    logic               was_active;
  } scc_in_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] depth;
    logic [31:0]        area;
    logic signed [31:0] gap_x;
    logic signed [31:0] gap_y;
    logic signed [31:0] gap_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               unbalance;
  } scc_out_t;

  // Data that rides along the square root pipeline.
  typedef struct packed {
    logic [2:0][31:0] s;
    logic [30:0]      rs;
    logic             was;
    logic [2:0][31:0] g;
  } sq_side_t;

  // Data that rides along the divider pipeline.
  typedef struct packed {
    logic [2:0][31:0]   s;
    logic [30:0]        rs;
    logic               was;
    logic [2:0][31:0]   g;
    logic signed [33:0] depth;
    logic               contact;
    logic               lenz;
  } dv_side_t;

  // Saturate a signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/scc_sqrt.sv
// Pipelined floor square root of a 64-bit value, four result bits per stage.
`default_nettype none

module scc_sqrt import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_x,
  input  sq_side_t    in_side,
  output logic        out_vld,
  output logic [31:0] out_root,
  output sq_side_t    out_side
);

  logic [SQRT_STAGES-1:0] vld_r;
  logic [35:0]            rem_r   [SQRT_STAGES];
  logic [31:0]            root_r  [SQRT_STAGES];
  logic [63:0]            x_r     [SQRT_STAGES];
  sq_side_t               side_r  [SQRT_STAGES];
  logic [35:0]            rem_src [SQRT_STAGES];
  logic [31:0]            root_src[SQRT_STAGES];
  logic [63:0]            x_src   [SQRT_STAGES];
  sq_side_t               side_src[SQRT_STAGES];
  logic [35:0]            rem_nxt [SQRT_STAGES];
  logic [31:0]            root_nxt[SQRT_STAGES];

  // Each stage starts from the previous stage's registers.
  always_comb begin
    rem_src[0]  = '0;
    root_src[0] = '0;
    x_src[0]    = in_x;
    side_src[0] = in_side;
    for (int j = 1; j < SQRT_STAGES; j++) begin
      rem_src[j]  = rem_r[j-1];
      root_src[j] = root_r[j-1];
      x_src[j]    = x_r[j-1];
      side_src[j] = side_r[j-1];
    end
  end

  // Digit-by-digit root: bring down two radicand bits, try root*4+1.
  always_comb begin
    logic [35:0] rem;
    logic [31:0] root;
    logic [35:0] trial;
    for (int j = 0; j < SQRT_STAGES; j++) begin
      rem  = rem_src[j];
      root = root_src[j];
      for (int t = 0; t < SQRT_STEPS; t++) begin
        rem   = {rem[33:0], x_src[j][63 - 2*(SQRT_STEPS*j + t) -: 2]};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[30:0], 1'b1};
        end else begin
          root = {root[30:0], 1'b0};
        end
      end
      rem_nxt[j]  = rem;
      root_nxt[j] = root;
    end
  end

  // Stage registers advance together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STAGES-2:0], in_vld};
    end
    if (en) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        x_r[j]    <= x_src[j];
        side_r[j] <= side_src[j];
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1];
  assign out_side = side_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

>>> design/scc_div.sv
// Pipelined restoring dividers for the overlap ratio and the three direction lanes.
`default_nettype none

module scc_div import scc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [62:0]              in_numq,
  input  logic [31:0]              in_denq,
  input  logic [2:0][45:0]         in_numd,
  input  logic [31:0]              in_dend,
  input  dv_side_t                 in_side,
  output logic                     out_vld,
  output logic [Q_BITS-1:0]        out_q,
  output logic [2:0][D_BITS-1:0]   out_qd,
  output dv_side_t                 out_side
);

  logic [DIV_STAGES-1:0]   vld_r;
  logic [62:0]             rq_r   [DIV_STAGES];
  logic [Q_BITS-1:0]       qq_r   [DIV_STAGES];
  logic [31:0]             dq_r   [DIV_STAGES];
  logic [2:0][45:0]        rd_r   [DIV_STAGES];
  logic [2:0][D_BITS-1:0]  qd_r   [DIV_STAGES];
  logic [31:0]             dd_r   [DIV_STAGES];
  dv_side_t                side_r [DIV_STAGES];
  logic [62:0]             rq_src [DIV_STAGES];
  logic [Q_BITS-1:0]       qq_src [DIV_STAGES];
  logic [31:0]             dq_src [DIV_STAGES];
  logic [2:0][45:0]        rd_src [DIV_STAGES];
  logic [2:0][D_BITS-1:0]  qd_src [DIV_STAGES];
  logic [31:0]             dd_src [DIV_STAGES];
  dv_side_t                side_src[DIV_STAGES];
  logic [62:0]             rq_nxt [DIV_STAGES];
  logic [Q_BITS-1:0]       qq_nxt [DIV_STAGES];
  logic [2:0][45:0]        rd_nxt [DIV_STAGES];
  logic [2:0][D_BITS-1:0]  qd_nxt [DIV_STAGES];

  // Each stage starts from the previous stage's registers.
  always_comb begin
    rq_src[0]   = in_numq;
    qq_src[0]   = '0;
    dq_src[0]   = in_denq;
    rd_src[0]   = in_numd;
    qd_src[0]   = '0;
    dd_src[0]   = in_dend;
    side_src[0] = in_side;
    for (int j = 1; j < DIV_STAGES; j++) begin
      rq_src[j]   = rq_r[j-1];
      qq_src[j]   = qq_r[j-1];
      dq_src[j]   = dq_r[j-1];
      rd_src[j]   = rd_r[j-1];
      qd_src[j]   = qd_r[j-1];
      dd_src[j]   = dd_r[j-1];
      side_src[j] = side_r[j-1];
    end
  end

  // Quotient bits from the top down; the quotient is known to fit its width.
  always_comb begin
    logic [62:0]       rq;
    logic [Q_BITS-1:0] qq;
    logic [62:0]       shq;
    logic [45:0]       rd;
    logic [D_BITS-1:0] qd;
    logic [45:0]       shd;
    int                n;
    for (int j = 0; j < DIV_STAGES; j++) begin
      rq = rq_src[j];
      qq = qq_src[j];
      for (int t = 0; t < QDIV_STEPS; t++) begin
        n = QDIV_STEPS*j + t;
        if (n < Q_BITS) begin
          shq = {31'b0, dq_src[j]} << (Q_BITS - 1 - n);
          if (rq >= shq) begin
            rq = rq - shq;
            qq = {qq[Q_BITS-2:0], 1'b1};
          end else begin
            qq = {qq[Q_BITS-2:0], 1'b0};
          end
        end
      end
      rq_nxt[j] = rq;
      qq_nxt[j] = qq;
      for (int l = 0; l < 3; l++) begin
        rd = rd_src[j][l];
        qd = qd_src[j][l];
        for (int t = 0; t < DDIV_STEPS; t++) begin
          n = DDIV_STEPS*j + t;
          if (n < D_BITS) begin
            shd = {14'b0, dd_src[j]} << (D_BITS - 1 - n);
            if (rd >= shd) begin
              rd = rd - shd;
              qd = {qd[D_BITS-2:0], 1'b1};
            end else begin
              qd = {qd[D_BITS-2:0], 1'b0};
            end
          end
        end
        rd_nxt[j][l] = rd;
        qd_nxt[j][l] = qd;
      end
    end
  end

  // Stage registers advance together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
    if (en) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        rq_r[j]   <= rq_nxt[j];
        qq_r[j]   <= qq_nxt[j];
        dq_r[j]   <= dq_src[j];
        rd_r[j]   <= rd_nxt[j];
        qd_r[j]   <= qd_nxt[j];
        dd_r[j]   <= dd_src[j];
        side_r[j] <= side_src[j];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_q    = qq_r[DIV_STAGES-1];
  assign out_qd   = qd_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> design/sphere_capsule_contact.sv
// Top level of the sphere against capsule contact pipeline.
// Usage:
//   The capsule (center, unit axis, radius, cylinder height) is set through the
//   APB-style port; write it only while no item is in flight. Reads return the
//   stored values, pready is always high.
//   Sphere items enter on in_valid/in_ready and results leave on
//   out_valid/out_ready, one result item for every input item, in order.
//   Throughput is one item per cycle while the receiver takes results: six
//   front stages (projection, clamp, gap, squares), an eight-stage square
//   root, two stages for depth and dividend, an eight-stage divider, and
//   three stages for area, impact point and the output register.
//   The whole pipeline advances as one; when the receiver holds out_ready low
//   with a result waiting, every stage holds and in_ready drops, so no item is
//   lost or repeated. Bubbles move through with their valid bits cleared.
//   Reset clears all valid bits and returns the capsule registers to a unit
//   radius, height two, axis along z, centered at the origin.
`default_nettype none

module sphere_capsule_contact import scc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output scc_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Capsule registers.
  logic signed [31:0] cen_r [3];
  logic signed [15:0] ax_r  [3];
  logic [30:0]        rc_r;
  logic [30:0]        ht_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      ax_r[0]  <= '0;
      ax_r[1]  <= '0;
      ax_r[2]  <= AXIS_Z_RST;
      rc_r     <= RADIUS_RST;
      ht_r     <= HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CEN_X:  cen_r[0] <= pwdata;
        REG_CEN_Y:  cen_r[1] <= pwdata;
        REG_CEN_Z:  cen_r[2] <= pwdata;
        REG_AXIS_X: ax_r[0]  <= pwdata[15:0];
        REG_AXIS_Y: ax_r[1]  <= pwdata[15:0];
        REG_AXIS_Z: ax_r[2]  <= pwdata[15:0];
        REG_RADIUS: rc_r     <= pwdata[30:0];
        REG_HEIGHT: ht_r     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_CEN_X:  prdata = cen_r[0];
      REG_CEN_Y:  prdata = cen_r[1];
      REG_CEN_Z:  prdata = cen_r[2];
      REG_AXIS_X: prdata = {16'b0, ax_r[0]};
      REG_AXIS_Y: prdata = {16'b0, ax_r[1]};
      REG_AXIS_Z: prdata = {16'b0, ax_r[2]};
      REG_RADIUS: prdata = {1'b0, rc_r};
      REG_HEIGHT: prdata = {1'b0, ht_r};
      default:    prdata = '0;
    endcase
  end

  // Global advance: the pipeline moves when the output register is empty or its result is being taken.
  logic en;
  logic out_valid_r;
  scc_out_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Front pipeline registers.
  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  scc_in_t            s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  logic signed [48:0] p_r  [3];
  logic signed [31:0] proj_r;
  logic signed [47:0] m_r  [3];
  logic signed [31:0] g4_r [3];
  logic [63:0]        sq_r [3];
  logic signed [31:0] g5_r [3];
  logic [63:0]        sum_r;
  logic signed [31:0] g6_r [3];

  logic signed [31:0] sv1  [3];
  logic signed [31:0] sv3  [3];
  logic signed [48:0] p_nxt [3];
  logic signed [31:0] proj_nxt;
  logic signed [47:0] m_nxt [3];
  logic signed [31:0] g_nxt [3];
  logic [63:0]        sq_nxt [3];
  logic [63:0]        sum_nxt;

  always_comb begin
    sv1[0] = in_data.sphere_x;
    sv1[1] = in_data.sphere_y;
    sv1[2] = in_data.sphere_z;
    sv3[0] = s3_r.sphere_x;
    sv3[1] = s3_r.sphere_y;
    sv3[2] = s3_r.sphere_z;
  end

  // Offset from the capsule center times the axis, per component.
  always_comb begin
    logic signed [32:0] rel;
    for (int i = 0; i < 3; i++) begin
      rel      = 33'(sv1[i]) - 33'(cen_r[i]);
      p_nxt[i] = 49'(rel) * 49'(ax_r[i]);
    end
  end

  // Dot product, floor to Q16.16, clamp to half the height.
  always_comb begin
    logic signed [50:0] dot;
    logic signed [36:0] shp;
    logic signed [36:0] hh;
    logic signed [36:0] cl;
    dot = 51'(p_r[0]) + 51'(p_r[1]) + 51'(p_r[2]);
    shp = 37'(dot >>> 14);
    hh  = {7'b0, ht_r[30:1]};
    if (shp > hh) begin
      cl = hh;
    end else if (shp < -hh) begin
      cl = -hh;
    end else begin
      cl = shp;
    end
    proj_nxt = 32'(cl);
  end

  // Projection back onto the axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = 48'(proj_r) * 48'(ax_r[i]);
    end
  end

  // Gap from the sphere center to the closest axis point.
  always_comb begin
    logic signed [33:0] mq;
    logic signed [35:0] gs;
    for (int i = 0; i < 3; i++) begin
      mq       = 34'(m_r[i] >>> 14);
      gs       = 36'(cen_r[i]) + 36'(mq) - 36'(sv3[i]);
      g_nxt[i] = sat32(64'(gs));
    end
  end

  // Squared gap components and their sum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = 64'(g4_r[i]) * 64'(g4_r[i]);
    end
    sum_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    if (en) begin
      s1_r   <= in_data;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      s4_r   <= s3_r;
      s5_r   <= s4_r;
      s6_r   <= s5_r;
      proj_r <= proj_nxt;
      sum_r  <= sum_nxt;
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= p_nxt[i];
        m_r[i]  <= m_nxt[i];
        g4_r[i] <= g_nxt[i];
        sq_r[i] <= sq_nxt[i];
        g5_r[i] <= g4_r[i];
        g6_r[i] <= g5_r[i];
      end
    end
  end

  // Gap length through the square root pipeline.
  sq_side_t    sq_in_side;
  sq_side_t    sq_out_side;
  logic        sq_out_vld;
  logic [31:0] sq_len;

  always_comb begin
    sq_in_side.s[0] = s6_r.sphere_x;
    sq_in_side.s[1] = s6_r.sphere_y;
    sq_in_side.s[2] = s6_r.sphere_z;
    sq_in_side.rs   = s6_r.sphere_radius;
    sq_in_side.was  = s6_r.was_active;
    for (int i = 0; i < 3; i++) begin
      sq_in_side.g[i] = g6_r[i];
    end
  end

  scc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v6_r),
    .in_x     (sum_r),
    .in_side  (sq_in_side),
    .out_vld  (sq_out_vld),
    .out_root (sq_len),
    .out_side (sq_out_side)
  );

  // Depth, then the divider operands.
  logic               vd1_r, vd2_r;
  logic signed [33:0] depth1_r;
  logic [31:0]        len1_r;
  sq_side_t           sd1_r;
  logic [62:0]        numq_r;
  logic [31:0]        denq_r;
  logic [2:0][45:0]   numd_r;
  logic [31:0]        len2_r;
  dv_side_t           sd2_r;
  logic signed [33:0] depth_nxt;
  logic [62:0]        numq_nxt;
  logic [31:0]        denq_nxt;
  logic [2:0][45:0]   numd_nxt;
  dv_side_t           sd2_nxt;

  assign depth_nxt = $signed({3'b0, sq_out_side.rs} + {3'b0, rc_r} - {2'b0, sq_len});

  always_comb begin
    logic        contact;
    logic [63:0] prod;
    logic [31:0] mag;
    contact  = depth1_r > 34'sd0;
    prod     = {31'b0, depth1_r[32:0]} * {33'b0, rc_r};
    numq_nxt = contact ? prod[62:0] : '0;
    denq_nxt = {1'b0, sd1_r.rs} + {1'b0, rc_r};
    for (int i = 0; i < 3; i++) begin
      mag         = sd1_r.g[i][31] ? (~sd1_r.g[i] + 32'd1) : sd1_r.g[i];
      numd_nxt[i] = {mag, 14'b0};
    end
    sd2_nxt.s       = sd1_r.s;
    sd2_nxt.rs      = sd1_r.rs;
    sd2_nxt.was     = sd1_r.was;
    sd2_nxt.g       = sd1_r.g;
    sd2_nxt.depth   = depth1_r;
    sd2_nxt.contact = contact;
    sd2_nxt.lenz    = (len1_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd1_r <= 1'b0;
      vd2_r <= 1'b0;
    end else if (en) begin
      vd1_r <= sq_out_vld;
      vd2_r <= vd1_r;
    end
    if (en) begin
      depth1_r <= depth_nxt;
      len1_r   <= sq_len;
      sd1_r    <= sq_out_side;
      numq_r   <= numq_nxt;
      denq_r   <= denq_nxt;
      numd_r   <= numd_nxt;
      len2_r   <= len1_r;
      sd2_r    <= sd2_nxt;
    end
  end

  // Overlap ratio and direction quotients.
  logic                   dv_out_vld;
  logic [Q_BITS-1:0]      dv_q;
  logic [2:0][D_BITS-1:0] dv_qd;
  dv_side_t               dv_side;

  scc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vd2_r),
    .in_numq  (numq_r),
    .in_denq  (denq_r),
    .in_numd  (numd_r),
    .in_dend  (len2_r),
    .in_side  (sd2_r),
    .out_vld  (dv_out_vld),
    .out_q    (dv_q),
    .out_qd   (dv_qd),
    .out_side (dv_side)
  );

  // Tail: overlap term, lever products, then area and impact point.
  logic               vt1_r, vt2_r;
  logic signed [63:0] diff_r;
  logic signed [49:0] ld_r   [3];
  logic signed [15:0] dir1_r [3];
  dv_side_t           st1_r;
  logic [63:0]        pm_r;
  logic               asat_r;
  logic               apos_r;
  logic signed [31:0] hit_r  [3];
  logic signed [15:0] dir2_r [3];
  dv_side_t           st2_r;
  logic signed [63:0] diff_nxt;
  logic signed [49:0] ld_nxt   [3];
  logic signed [15:0] dir_nxt  [3];
  logic [63:0]        pm_nxt;
  logic               asat_nxt;
  logic               apos_nxt;
  logic signed [31:0] hit_nxt  [3];
  scc_out_t           out_nxt;

  always_comb begin
    logic signed [32:0] qs;
    logic signed [32:0] u;
    logic signed [33:0] lever;
    logic signed [15:0] qmag;
    qs       = {2'b0, dv_q};
    u        = $signed({1'b0, dv_side.rs, 1'b0}) - qs;
    diff_nxt = 64'(qs) * 64'(u);
    lever    = $signed({3'b0, dv_side.rs}) - (dv_side.depth >>> 1);
    for (int i = 0; i < 3; i++) begin
      qmag = {1'b0, dv_qd[i]};
      if (dv_side.lenz) begin
        dir_nxt[i] = '0;
      end else if (dv_side.g[i][31]) begin
        dir_nxt[i] = -qmag;
      end else begin
        dir_nxt[i] = qmag;
      end
      ld_nxt[i] = 50'(lever) * 50'(dir_nxt[i]);
    end
  end

  always_comb begin
    logic [47:0]        d16;
    logic signed [63:0] hs;
    apos_nxt = diff_r > 64'sd0;
    d16      = diff_r[63:16];
    asat_nxt = |d16[47:32];
    pm_nxt   = {32'b0, d16[31:0]} * {32'b0, PI_Q30};
    for (int i = 0; i < 3; i++) begin
      hs = 64'($signed(st1_r.s[i])) + 64'(ld_r[i] >>> 14);
      hit_nxt[i] = st1_r.contact ? sat32(hs) : '0;
    end
  end

  // Output item.
  always_comb begin
    out_nxt.depth = sat32(64'(st2_r.depth));
    if (!st2_r.contact || !apos_r) begin
      out_nxt.area = '0;
    end else if (asat_r || (|pm_r[63:62])) begin
      out_nxt.area = 32'hFFFFFFFF;
    end else begin
      out_nxt.area = pm_r[61:30];
    end
    out_nxt.gap_x     = st2_r.g[0];
    out_nxt.gap_y     = st2_r.g[1];
    out_nxt.gap_z     = st2_r.g[2];
    out_nxt.dir_x     = dir2_r[0];
    out_nxt.dir_y     = dir2_r[1];
    out_nxt.dir_z     = dir2_r[2];
    out_nxt.hit_x     = hit_r[0];
    out_nxt.hit_y     = hit_r[1];
    out_nxt.hit_z     = hit_r[2];
    out_nxt.unbalance = st2_r.contact && !st2_r.was;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt1_r       <= 1'b0;
      vt2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vt1_r       <= dv_out_vld;
      vt2_r       <= vt1_r;
      out_valid_r <= vt2_r;
    end
    if (en) begin
      diff_r     <= diff_nxt;
      st1_r      <= dv_side;
      pm_r       <= pm_nxt;
      asat_r     <= asat_nxt;
      apos_r     <= apos_nxt;
      st2_r      <= st1_r;
      out_data_r <= out_nxt;
      for (int i = 0; i < 3; i++) begin
        ld_r[i]   <= ld_nxt[i];
        dir1_r[i] <= dir_nxt[i];
        hit_r[i]  <= hit_nxt[i];
        dir2_r[i] <= dir1_r[i];
      end
    end
  end

  // Checks on the block's own logic.
`include "sphere_capsule_contact_assert.svh"

  `SCC_CHK_IMP(a_no_contact_quiet, out_valid && (out_data.depth[31] || out_data.depth == '0), out_data.area == '0 && out_data.unbalance == 1'b0 && out_data.hit_x == '0)
  `SCC_CHK_IMP(a_zero_gap_no_dir, out_valid && out_data.gap_x == '0 && out_data.gap_y == '0 && out_data.gap_z == '0, out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
  `SCC_CHK_NXT(a_ready_after_take, out_valid && out_ready, in_ready || out_valid)

endmodule

`default_nettype wire
